### rtl/srcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srcc_pkg;

    localparam logic [2:0] POS_HIGH0 = 3'd0;
    localparam logic [2:0] POS_LOW0  = 3'd1;
    localparam logic [2:0] POS_CRC0  = 3'd2;
    localparam logic [2:0] POS_HIGH1 = 3'd3;
    localparam logic [2:0] POS_LOW1  = 3'd4;
    localparam logic [2:0] POS_CRC1  = 3'd5;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FIRST_BAD  = 2'd1;
    localparam logic [1:0] STATUS_SECOND_BAD = 2'd2;

    typedef struct packed {
        logic signed [14:0] temp_centi_c;
        logic [13:0]        humid_centi_pct;
        logic               humid_cropped;
    } conv_t;

    function automatic logic [7:0] crc8_take(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/srcc_conv.sv
`timescale 1ns / 1ps
`default_nettype none

module srcc_conv
    import srcc_pkg::*;
(
    input  wire logic [15:0] first_word,
    input  wire logic [15:0] second_word,
    output conv_t            res
);

    localparam logic [14:0] TEMP_SCALE   = 15'd17500;
    localparam logic [13:0] HUM_SCALE    = 14'd12500;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4500;
    localparam logic [14:0] HUM_OFFSET   = 15'd600;
    localparam logic [13:0] HUM_FULL     = 14'd10000;
    localparam logic [29:0] HUM_HIGH_LIM = 30'd694671000;
    localparam logic [29:0] HUM_LOW_LIM  = 30'd39321000;
    localparam logic [30:0] HALF_SCALE   = 31'd32767;
    localparam logic [16:0] FULL_SCALE   = 17'd65535;

    // round(num / 65535): one add and compare after the shift
    function automatic logic [14:0] div_full_round(input logic [30:0] num);
        logic [30:0] y;
        logic [14:0] q0;
        logic [16:0] r;
        y  = num + HALF_SCALE;
        q0 = y[30:16];
        r  = {1'b0, y[15:0]} + {2'b0, q0};
        return (r >= FULL_SCALE) ? q0 + 15'd1 : q0;
    endfunction

    logic [30:0] temp_num;
    logic [29:0] hum_num;
    logic [14:0] temp_q;
    logic [15:0] temp_full;
    logic [14:0] hum_q;
    logic [14:0] hum_diff;

    assign temp_num  = {15'b0, first_word} * {16'b0, TEMP_SCALE};
    assign hum_num   = {14'b0, second_word} * {16'b0, HUM_SCALE};
    assign temp_q    = div_full_round(temp_num);
    assign temp_full = {1'b0, temp_q} - TEMP_OFFSET;
    assign hum_q     = div_full_round({1'b0, hum_num});
    assign hum_diff  = hum_q - HUM_OFFSET;

    always_comb begin
        res.temp_centi_c = signed'(temp_full[14:0]);
        if (hum_num > HUM_HIGH_LIM) begin
            res.humid_centi_pct = HUM_FULL;
            res.humid_cropped   = 1'b1;
        end else if (hum_num < HUM_LOW_LIM) begin
            res.humid_centi_pct = 14'd0;
            res.humid_cropped   = 1'b1;
        end else begin
            res.humid_centi_pct = hum_diff[13:0];
            res.humid_cropped   = 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/sensor_reply_crc_check_and_convert_top.sv
// Sensor reply checker and converter.
// Input channel (s_valid/s_ready): one reply byte per item, s_reply_start
// marks the first byte of a reply and restarts the byte count and CRC.
// A reply is a big-endian word, its CRC-8 (poly 0x31, init 0xFF), a second
// word and its CRC-8. Without a start flag the count wraps after six bytes.
// Output channel (m_valid/m_ready): one item per six-byte reply, holding
// both words, the CRC status, temperature in 0.01 C and humidity in
// 0.01 %RH cropped to 0..10000 with a crop flag.
// The result is registered and valid in the cycle after the sixth byte is accepted.
// Throughput: one byte per cycle unless s_ready is low; the whole conversion for a
// reply is combinational between the held word registers and the output register.
// When the receiver stalls, bytes one to five of the next reply are still
// accepted; its sixth byte waits until the pending result is taken.
// Reset (aresetn low, synchronous) clears the byte count, sets the CRC to
// 0xFF, clears the first-word check and clears the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module sensor_reply_crc_check_and_convert_top
    import srcc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire logic               s_reply_start,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_first_word,
    output logic [15:0]             m_second_word,
    output logic [1:0]              m_check_status,
    output logic signed [14:0]      m_temp_centi_c,
    output logic [13:0]             m_humid_centi_pct,
    output logic                    m_humid_cropped
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        first_good_reg, first_good_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] first_word_reg, first_word_next;
    logic [15:0] second_word_reg, second_word_next;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_first_reg;
    logic [15:0] m_second_reg;
    logic [1:0]  m_status_reg;
    conv_t       m_conv_reg;

    logic        restart;
    logic [2:0]  pos_cur;
    logic [7:0]  crc_cur;
    logic [7:0]  crc_upd;
    logic        emit;
    logic        accept;
    logic [1:0]  status;
    conv_t       conv;

    srcc_conv u_conv (
        .first_word  (first_word_reg),
        .second_word (second_word_reg),
        .res         (conv)
    );

    assign restart = s_reply_start || (pos_reg > POS_CRC1);
    assign pos_cur = restart ? POS_HIGH0 : pos_reg;
    assign crc_cur = restart ? CRC_INIT : crc_reg;
    assign crc_upd = crc8_take(crc_cur, s_rx_byte);
    assign emit    = (pos_cur == POS_CRC1);
    assign s_ready = !emit || !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign status = !first_good_reg ? STATUS_FIRST_BAD
                  : (crc_cur != s_rx_byte) ? STATUS_SECOND_BAD : STATUS_OK;

    always_comb begin
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        first_good_next  = first_good_reg;
        high_next        = high_reg;
        first_word_next  = first_word_reg;
        second_word_next = second_word_reg;
        if (accept) begin
            pos_next = pos_cur + 3'd1;
            case (pos_cur)
                POS_HIGH0, POS_HIGH1: begin
                    crc_next  = crc_upd;
                    high_next = s_rx_byte;
                end
                POS_LOW0: begin
                    crc_next        = crc_upd;
                    first_word_next = {high_reg, s_rx_byte};
                end
                POS_CRC0: begin
                    first_good_next = (crc_cur == s_rx_byte);
                    crc_next        = CRC_INIT;
                end
                POS_LOW1: begin
                    crc_next         = crc_upd;
                    second_word_next = {high_reg, s_rx_byte};
                end
                default: begin
                    pos_next = POS_HIGH0;
                    crc_next = CRC_INIT;
                end
            endcase
        end
    end

    always_comb begin
        if (accept && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_HIGH0;
            crc_reg        <= CRC_INIT;
            first_good_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            first_good_reg <= first_good_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        high_reg        <= high_next;
        first_word_reg  <= first_word_next;
        second_word_reg <= second_word_next;
        if (accept && emit) begin
            m_first_reg  <= first_word_reg;
            m_second_reg <= second_word_reg;
            m_status_reg <= status;
            m_conv_reg   <= conv;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_first_word      = m_first_reg;
    assign m_second_word     = m_second_reg;
    assign m_check_status    = m_status_reg;
    assign m_temp_centi_c    = m_conv_reg.temp_centi_c;
    assign m_humid_centi_pct = m_conv_reg.humid_centi_pct;
    assign m_humid_cropped   = m_conv_reg.humid_cropped;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_CRC1)
        else $error("byte position out of range");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit) |=> m_valid)
        else $error("sixth byte accepted without a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && emit) |-> !s_ready)
        else $error("pending result would be overwritten");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_check_status == STATUS_OK || m_check_status == STATUS_FIRST_BAD
                     || m_check_status == STATUS_SECOND_BAD))
        else $error("invalid check status");

endmodule

`default_nettype wire
